[src/abkf_pkg.sv]
// ---------------------------------------------------------------------------
// abkf_pkg
// Shared types, constants and status codes of the angle / bias filter.
// ---------------------------------------------------------------------------
package abkf_pkg;

    localparam int W_BITS = 32;
    localparam int F_BITS = 24;
    localparam int CFG_BITS = 31;
    localparam int IDX_BITS = 2;

    localparam logic signed [W_BITS-1:0] W_MAX = {1'b0, {(W_BITS-1){1'b1}}};
    localparam logic signed [W_BITS-1:0] W_MIN = {1'b1, {(W_BITS-1){1'b0}}};
    localparam logic signed [W_BITS-1:0] Q_ONE = W_BITS'(64'd1 << F_BITS);

    localparam logic [CFG_BITS-1:0] DEF_ANGLE_NOISE = CFG_BITS'(((64'd1 << F_BITS) + 64'd500) / 64'd1000);
    localparam logic [CFG_BITS-1:0] DEF_BIAS_NOISE  = CFG_BITS'(((64'd3 << F_BITS) + 64'd500) / 64'd1000);
    localparam logic [CFG_BITS-1:0] DEF_MEAS_NOISE  = CFG_BITS'(((64'd3 << F_BITS) + 64'd50) / 64'd100);

    // 2*pi rounded to the format (Q60 source constant)
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
    localparam logic signed [W_BITS-1:0] TWO_PI =
        W_BITS'((TWO_PI_Q60 + (64'd1 << (59 - F_BITS))) >> (60 - F_BITS));

    localparam logic [IDX_BITS-1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_MEAS_NOISE  = 2'd2;

    typedef enum logic [2:0] {
        ST_CORRECTED  = 3'd0,
        ST_PREDICT    = 3'd1,
        ST_BAD_STEP   = 3'd2,
        ST_RESEEDED   = 3'd3,
        ST_CORR_SKIP  = 3'd4
    } t_status;

    typedef logic signed [W_BITS-1:0] t_word;

    typedef struct packed {
        logic        op;
        t_word       angle_obs;
        t_word       gyro_omega;
        t_word       time_step;
        logic        angle_valid;
    } t_in_beat;

    typedef struct packed {
        t_word       angle_estimate;
        t_word       bias_estimate;
        logic [2:0]  step_status;
    } t_out_beat;

    // saturating add / sub of two words
    function automatic t_word sat_add(t_word a, t_word b);
        logic signed [W_BITS:0] s;
        s = {a[W_BITS-1], a} + {b[W_BITS-1], b};
        if (s[W_BITS] != s[W_BITS-1]) return s[W_BITS] ? W_MIN : W_MAX;
        return s[W_BITS-1:0];
    endfunction

    function automatic t_word sat_sub(t_word a, t_word b);
        logic signed [W_BITS:0] s;
        s = {a[W_BITS-1], a} - {b[W_BITS-1], b};
        if (s[W_BITS] != s[W_BITS-1]) return s[W_BITS] ? W_MIN : W_MAX;
        return s[W_BITS-1:0];
    endfunction

endpackage

[src/abkf_if.sv]
// ---------------------------------------------------------------------------
// abkf_if
// Valid / ready channel carrying one payload beat.
// ---------------------------------------------------------------------------
interface abkf_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/abkf_mul.sv]
// ---------------------------------------------------------------------------
// abkf_mul
// Shift-and-add signed fixed-point multiplier, one multiplier bit per cycle,
// rounding half away from zero and saturating to the word range.
// ---------------------------------------------------------------------------
module abkf_mul
    import abkf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_a,
    input  t_word i_b,
    output logic  o_done,
    output t_word o_p
);
    localparam int CNT_BITS = $clog2(W_BITS + 1);

    logic [W_BITS-1:0]   r_ma, n_ma;
    logic [W_BITS-1:0]   r_mb, n_mb;
    logic [2*W_BITS-1:0] r_acc, n_acc;
    logic                r_neg, n_neg;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    t_word               r_p, n_p;

    logic [2*W_BITS-1:0] w_rnd;
    logic [2*W_BITS-1:0] w_mag;
    logic [W_BITS:0]     w_lim;

    always_comb begin
        n_ma   = r_ma;
        n_mb   = r_mb;
        n_acc  = r_acc;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_p    = r_p;
        w_rnd  = r_acc + (2*W_BITS)'(64'd1 << (F_BITS - 1));
        w_mag  = w_rnd >> F_BITS;
        w_lim  = r_neg ? {1'b0, 1'b1, {(W_BITS-1){1'b0}}} : {2'b00, {(W_BITS-1){1'b1}}};
        if (i_start) begin
            n_ma   = i_a[W_BITS-1] ? W_BITS'(-i_a) : i_a;
            n_mb   = i_b[W_BITS-1] ? W_BITS'(-i_b) : i_b;
            n_neg  = i_a[W_BITS-1] ^ i_b[W_BITS-1];
            n_acc  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_cnt == CNT_BITS'(W_BITS)) begin
                // saturate magnitude, then apply sign
                if (w_mag > (2*W_BITS)'(w_lim)) n_p = r_neg ? W_MIN : W_MAX;
                else n_p = r_neg ? W_BITS'(-w_mag[W_BITS-1:0]) : w_mag[W_BITS-1:0];
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                // consume multiplier bits msb first
                n_acc = (r_acc << 1) + (r_mb[W_BITS-1] ? (2*W_BITS)'(r_ma) : '0);
                n_mb  = r_mb << 1;
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_acc <= n_acc;
        r_neg <= n_neg;
        r_p   <= n_p;
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule

[src/abkf_div.sv]
// ---------------------------------------------------------------------------
// abkf_div
// Restoring divider for fixed-point a / b (b positive), one quotient bit per
// cycle, truncating toward zero and saturating.
// ---------------------------------------------------------------------------
module abkf_div
    import abkf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_a,
    input  t_word i_b,
    output logic  o_done,
    output t_word o_q
);
    localparam int N_BITS   = W_BITS + F_BITS;
    localparam int CNT_BITS = $clog2(N_BITS + 1);

    logic [N_BITS-1:0]   r_num, n_num;
    logic [N_BITS-1:0]   r_quo, n_quo;
    logic [W_BITS:0]     r_rem, n_rem;
    logic [W_BITS-1:0]   r_den, n_den;
    logic                r_neg, n_neg;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    t_word               r_q, n_q;

    logic [W_BITS:0]     w_sh;
    logic [N_BITS-1:0]   w_lim;
    logic [W_BITS-1:0]   w_ma;

    always_comb begin
        n_num  = r_num;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_q    = r_q;
        w_sh   = {r_rem[W_BITS-1:0], r_num[N_BITS-1]};
        w_lim  = r_neg ? N_BITS'({1'b1, {(W_BITS-1){1'b0}}})
                       : N_BITS'({(W_BITS-1){1'b1}});
        w_ma   = i_a[W_BITS-1] ? W_BITS'(-i_a) : i_a;
        if (i_start) begin
            n_num  = {w_ma, {F_BITS{1'b0}}};
            n_den  = i_b;
            n_neg  = i_a[W_BITS-1];
            n_quo  = '0;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_cnt == CNT_BITS'(N_BITS)) begin
                if (r_quo > w_lim) n_q = r_neg ? W_MIN : W_MAX;
                else n_q = r_neg ? W_BITS'(-r_quo[W_BITS-1:0]) : r_quo[W_BITS-1:0];
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_num = r_num << 1;
                if (w_sh >= {1'b0, r_den}) begin
                    n_rem = w_sh - {1'b0, r_den};
                    n_quo = {r_quo[N_BITS-2:0], 1'b1};
                end else begin
                    n_rem = w_sh;
                    n_quo = {r_quo[N_BITS-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

[src/angle_bias_kalman_filter.sv]
// ---------------------------------------------------------------------------
// angle_bias_kalman_filter
// Two-state angle / gyro-bias Kalman filter in saturating Q8.24.
// ---------------------------------------------------------------------------
// Usage:
//   in_if  : one beat per IMU sample (op, angle_obs, gyro_omega,
//            time_step, angle_valid), valid/ready.
//   out_if : one beat per input beat (angle, bias, step_status).
//   cfg    : i_cfg_we / i_cfg_idx / i_cfg_data write the three noise
//            registers; a zero register selects its default. Write only idle.
// Operation: one item at a time. A reseed or bad step goes straight to
//   the output; a prediction runs five serial multiplies, and a
//   correction adds an angle wrap, two divides and six more multiplies,
//   all on the bit-serial multiplier and divider.
// Reset: state returns to angle 0, bias 0, covariance identity, registers
//   to their defaults. A stalled output holds its beat in the output
//   register; the next input beat is taken while that beat waits.
// ---------------------------------------------------------------------------
module angle_bias_kalman_filter
    import abkf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    abkf_if.sink                in_if,
    abkf_if.source              out_if
);
    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_DISP   = 12'b000000000010,
        S_MUL    = 12'b000000000100,
        S_MWAIT  = 12'b000000001000,
        S_CHECK  = 12'b000000010000,
        S_WRAP   = 12'b000000100000,
        S_DIV    = 12'b000001000000,
        S_DWAIT  = 12'b000010000000,
        S_CMUL   = 12'b000100000000,
        S_CWAIT  = 12'b001000000000,
        S_EMIT   = 12'b010000000000,
        S_HOLD   = 12'b100000000000
    } t_state;

    t_state      r_state, n_state;
    logic [2:0]  r_step, n_step;
    t_in_beat    r_in;
    t_word       r_ang, r_bias, r_p00, r_p01, r_p10, r_p11;
    t_word       r_t, r_innov, r_k0, r_k1, r_s;
    logic [W_BITS-1:0] r_wmag;
    logic        r_wneg;
    logic [2:0]  r_status;
    logic [CFG_BITS-1:0] r_qa, r_qb, r_rm;
    logic        r_ovalid;
    t_out_beat   r_obeat;

    t_word       w_qa, w_qb, w_rm;
    logic        w_mstart, w_mdone, w_dstart, w_ddone;
    t_word       w_ma, w_mb, w_mp, w_da, w_db, w_dq;
    logic        w_in_acc, w_out_free;
    t_word       w_dwr;
    logic [W_BITS-1:0] w_tsh;
    logic        w_fold;

    assign w_qa = (r_qa == '0) ? t_word'(DEF_ANGLE_NOISE) : t_word'(r_qa);
    assign w_qb = (r_qb == '0) ? t_word'(DEF_BIAS_NOISE)  : t_word'(r_qb);
    assign w_rm = (r_rm == '0) ? t_word'(DEF_MEAS_NOISE)  : t_word'(r_rm);

    assign w_out_free = !r_ovalid || out_if.ready;
    assign in_if.ready = (r_state == S_IDLE);
    assign w_in_acc = in_if.valid && in_if.ready;

    abkf_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart),
        .i_a(w_ma), .i_b(w_mb), .o_done(w_mdone), .o_p(w_mp)
    );
    abkf_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_a(w_da), .i_b(w_db), .o_done(w_ddone), .o_q(w_dq)
    );

    // operand select per multiply and divide step
    always_comb begin
        w_ma = r_in.time_step;
        w_mb = r_p11;
        w_da = (r_step == 3'd0) ? r_p00 : r_p10;
        w_db = r_s;
        if (r_state == S_MUL) begin
            case (r_step)
                3'd0: w_mb = sat_sub(r_in.gyro_omega, r_bias);
                3'd1: w_mb = r_p11;
                3'd2: w_mb = r_t;
                3'd3: w_mb = r_p11;
                default: begin
                    w_ma = w_qb;
                    w_mb = r_in.time_step;
                end
            endcase
        end else begin
            // bias row first, so both rows see the predicted covariance
            case (r_step)
                3'd0: begin w_ma = r_k0; w_mb = r_innov; end
                3'd1: begin w_ma = r_k1; w_mb = r_innov; end
                3'd2: begin w_ma = r_k1; w_mb = r_p00; end
                3'd3: begin w_ma = r_k1; w_mb = r_p01; end
                3'd4: begin w_ma = r_k0; w_mb = r_p00; end
                default: begin w_ma = r_k0; w_mb = r_p01; end
            endcase
        end
    end

    assign w_mstart = (r_state == S_MUL) || (r_state == S_CMUL);
    assign w_dstart = (r_state == S_DIV);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_DISP;
            S_DISP: begin
                n_step = '0;
                if (r_in.op || r_in.time_step <= 0) n_state = S_EMIT;
                else n_state = S_MUL;
            end
            S_MUL:   n_state = S_MWAIT;
            S_MWAIT: if (w_mdone) begin
                if (r_step == 3'd4) n_state = S_CHECK;
                else begin
                    n_step  = r_step + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_CHECK: begin
                n_step = '0;
                if (!r_in.angle_valid || r_s <= 0) n_state = S_EMIT;
                else n_state = S_WRAP;
            end
            S_WRAP: begin
                if (r_step == 3'd5) begin
                    n_step  = '0;
                    n_state = S_DIV;
                end else begin
                    n_step  = r_step + 1'b1;
                end
            end
            S_DIV:   n_state = S_DWAIT;
            S_DWAIT: if (w_ddone) begin
                if (r_step == 3'd1) begin
                    n_step  = '0;
                    n_state = S_CMUL;
                end else begin
                    n_step  = 3'd1;
                    n_state = S_DIV;
                end
            end
            S_CMUL:  n_state = S_CWAIT;
            S_CWAIT: if (w_mdone) begin
                if (r_step == 3'd5) n_state = S_EMIT;
                else begin
                    n_step  = r_step + 1'b1;
                    n_state = S_CMUL;
                end
            end
            S_EMIT:  n_state = w_out_free ? S_IDLE : S_HOLD;
            S_HOLD:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // reduce |d| mod 2*pi by shifted subtracts, then fold into [-pi, pi]
    assign w_dwr  = sat_sub(r_in.angle_obs, r_ang);
    assign w_fold = {r_wmag, 1'b0} > {1'b0, TWO_PI};
    always_comb begin
        case (r_step)
            3'd0: w_tsh = {TWO_PI[W_BITS-5:0], 4'b0000};
            3'd1: w_tsh = {TWO_PI[W_BITS-4:0], 3'b000};
            3'd2: w_tsh = {TWO_PI[W_BITS-3:0], 2'b00};
            3'd3: w_tsh = {TWO_PI[W_BITS-2:0], 1'b0};
            default: w_tsh = TWO_PI;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
            r_qa     <= DEF_ANGLE_NOISE;
            r_qb     <= DEF_BIAS_NOISE;
            r_rm     <= DEF_MEAS_NOISE;
            r_ang    <= '0;
            r_bias   <= '0;
            r_p00    <= Q_ONE;
            r_p01    <= '0;
            r_p10    <= '0;
            r_p11    <= Q_ONE;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ANGLE_NOISE: r_qa <= i_cfg_data;
                    REG_BIAS_NOISE:  r_qb <= i_cfg_data;
                    REG_MEAS_NOISE:  r_rm <= i_cfg_data;
                    default: ;
                endcase
            end
            if ((r_state == S_EMIT || r_state == S_HOLD) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && out_if.ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_DISP) begin
                if (r_in.op) begin
                    r_ang  <= r_in.angle_obs;
                    r_bias <= '0;
                    r_p00  <= Q_ONE;
                    r_p01  <= '0;
                    r_p10  <= '0;
                    r_p11  <= Q_ONE;
                end
            end
            if (r_state == S_MWAIT && w_mdone) begin
                case (r_step)
                    3'd0: r_ang <= sat_add(r_ang, w_mp);
                    3'd1: r_t <= sat_add(sat_sub(sat_sub(w_mp, r_p01), r_p10), w_qa);
                    3'd2: r_p00 <= sat_add(r_p00, w_mp);
                    3'd3: begin
                        r_p01 <= sat_sub(r_p01, w_mp);
                        r_p10 <= sat_sub(r_p10, w_mp);
                    end
                    default: r_p11 <= sat_add(r_p11, w_mp);
                endcase
            end
            if (r_state == S_CWAIT && w_mdone) begin
                case (r_step)
                    3'd0: r_ang  <= sat_add(r_ang, w_mp);
                    3'd1: r_bias <= sat_add(r_bias, w_mp);
                    3'd2: r_p10  <= sat_sub(r_p10, w_mp);
                    3'd3: r_p11  <= sat_sub(r_p11, w_mp);
                    3'd4: r_p00  <= sat_sub(r_p00, w_mp);
                    default: r_p01 <= sat_sub(r_p01, w_mp);
                endcase
            end
        end
        if (w_in_acc) r_in <= in_if.data;
        if (r_state == S_CHECK) begin
            r_s    <= sat_add(r_p00, w_rm);
            r_wneg <= w_dwr[W_BITS-1];
            r_wmag <= w_dwr[W_BITS-1] ? W_BITS'(-w_dwr) : w_dwr;
        end
        if (r_state == S_MWAIT && w_mdone && r_step == 3'd4) r_s <= sat_add(r_p00, w_rm);
        if (r_state == S_WRAP) begin
            if (r_step != 3'd5) begin
                if (r_wmag >= w_tsh) r_wmag <= r_wmag - w_tsh;
            end else if (w_fold) begin
                r_innov <= r_wneg ? t_word'(TWO_PI - r_wmag) : t_word'(r_wmag - TWO_PI);
            end else begin
                r_innov <= r_wneg ? t_word'(-r_wmag) : t_word'(r_wmag);
            end
        end
        if (r_state == S_DWAIT && w_ddone) begin
            if (r_step == 3'd0) r_k0 <= w_dq;
            else r_k1 <= w_dq;
        end
        if (r_state == S_DISP) begin
            if (r_in.op) r_status <= ST_RESEEDED;
            else if (r_in.time_step <= 0) r_status <= ST_BAD_STEP;
        end
        if (r_state == S_CHECK) begin
            if (!r_in.angle_valid) r_status <= ST_PREDICT;
            else if (r_s <= 0) r_status <= ST_CORR_SKIP;
        end
        if (r_state == S_CWAIT && w_mdone && r_step == 3'd5) r_status <= ST_CORRECTED;
        if ((r_state == S_EMIT || r_state == S_HOLD) && w_out_free) begin
            r_obeat.angle_estimate <= r_ang;
            r_obeat.bias_estimate  <= r_bias;
            r_obeat.step_status    <= r_status;
        end
    end

    assign out_if.valid = r_ovalid;
    assign out_if.data  = r_obeat;

    // when the output is free, emit leaves for idle at once, with the output beat loaded
    a_emit_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free) |=> r_state == S_IDLE && r_ovalid)
        else $error("emit did not load output");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !in_if.ready)
        else $error("input ready while busy");
    a_units_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mstart && w_dstart))
        else $error("multiplier and divider started together");
endmodule

[test/tb_angle_bias_kalman_filter.sv]
// ---------------------------------------------------------------------------
// tb_angle_bias_kalman_filter
// Self-checking bench for the angle / gyro-bias Kalman filter: a directed
// table of samples, then random IMU-like traffic with random idling on both
// channels, checked beat by beat against a saturating Q8.24 predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_angle_bias_kalman_filter;
    import abkf_pkg::*;

    localparam int WD_LIMIT = 20000;
    localparam int N_RANDOM = 600;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam logic [IDX_BITS-1:0] REG_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_BITS-1:0] i_cfg_data;

    abkf_if #(.T(t_in_beat))  in_if ();
    abkf_if #(.T(t_out_beat)) out_if ();

    angle_bias_kalman_filter DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .in_if(in_if.sink), .out_if(out_if.source)
    );

    // filter state of the predictor
    longint est_angle, est_bias, p00, p01, p10, p11;
    longint noise_q, noise_b, noise_r;
    t_out_beat estimate_q[$];
    t_out_beat last_out;
    int errors = 0;
    int n_beats_out = 0;
    int idle_cycles = 0;
    bit sink_idle_en = 1;
    bit src_idle_en = 1;
    int hold_off = 0;
    int st_count[5];

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint clampw(longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    // words stay within 32 bits, so 64-bit sums never overflow
    function automatic longint qadd(longint a, longint b);
        return clampw(a + b);
    endfunction

    function automatic longint qsub(longint a, longint b);
        return clampw(a - b);
    endfunction

    function automatic longint sat_mag(bit neg, logic [127:0] m);
        logic [127:0] lim;
        lim = neg ? 128'd2147483648 : 128'd2147483647;
        if (m > lim) m = lim;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    // product rounded half away from zero
    function automatic longint qmul(longint a, longint b);
        logic [127:0] m;
        longint ma, mb;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        m = 128'(ma) * 128'(mb);
        m = (m + (128'd1 << (F_BITS - 1))) >> F_BITS;
        return sat_mag((a < 0) != (b < 0), m);
    endfunction

    // quotient truncated toward zero, divisor positive
    function automatic longint qdiv(longint a, longint b);
        logic [127:0] m;
        longint ma;
        ma = a < 0 ? -a : a;
        m = (128'(ma) << F_BITS) / 128'(b);
        return sat_mag(a < 0, m);
    endfunction

    function automatic longint wrap_pi(longint d);
        longint t, r;
        t = longint'(TWO_PI);
        r = d % t;
        if (r * 2 > t) r -= t;
        else if (r * 2 < -t) r += t;
        return clampw(r);
    endfunction

    function automatic longint pick_noise(longint v, longint dflt);
        return v == 0 ? dflt : v;
    endfunction

    task automatic reseed_state(longint a);
        est_angle = a;
        est_bias = 0;
        p00 = longint'(Q_ONE);
        p01 = 0;
        p10 = 0;
        p11 = longint'(Q_ONE);
    endtask

    task automatic filter_step(t_in_beat b);
        longint meas, gyro, dt, qa, qb, rm, t, d11, s, innov, k0, k1, a00, a01;
        t_out_beat r;
        t_status st;
        meas = longint'(b.angle_obs);
        gyro = longint'(b.gyro_omega);
        dt = longint'(b.time_step);
        if (b.op) begin
            reseed_state(meas);
            st = ST_RESEEDED;
        end else if (dt <= 0) begin
            st = ST_BAD_STEP;
        end else begin
            qa = pick_noise(noise_q, longint'(DEF_ANGLE_NOISE));
            qb = pick_noise(noise_b, longint'(DEF_BIAS_NOISE));
            rm = pick_noise(noise_r, longint'(DEF_MEAS_NOISE));
            est_angle = qadd(est_angle, qmul(dt, qsub(gyro, est_bias)));
            t = qsub(qmul(dt, p11), p01);
            t = qadd(qsub(t, p10), qa);
            p00 = qadd(p00, qmul(dt, t));
            d11 = qmul(dt, p11);
            p01 = qsub(p01, d11);
            p10 = qsub(p10, d11);
            p11 = qadd(p11, qmul(qb, dt));
            if (!b.angle_valid) begin
                st = ST_PREDICT;
            end else begin
                s = qadd(p00, rm);
                if (s <= 0) begin
                    st = ST_CORR_SKIP;
                end else begin
                    innov = wrap_pi(qsub(meas, est_angle));
                    k0 = qdiv(p00, s);
                    k1 = qdiv(p10, s);
                    a00 = p00;
                    a01 = p01;
                    est_angle = qadd(est_angle, qmul(k0, innov));
                    est_bias = qadd(est_bias, qmul(k1, innov));
                    p00 = qsub(p00, qmul(k0, a00));
                    p01 = qsub(p01, qmul(k0, a01));
                    p10 = qsub(p10, qmul(k1, a00));
                    p11 = qsub(p11, qmul(k1, a01));
                    st = ST_CORRECTED;
                end
            end
        end
        r.angle_estimate = t_word'(est_angle);
        r.bias_estimate = t_word'(est_bias);
        r.step_status = st;
        estimate_q.push_back(r);
    endtask

    // predict at acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) filter_step(in_if.data);
    end

    // compare each delivered beat with the oldest estimate
    always @(posedge i_clk) begin
        t_out_beat e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            last_out = out_if.data;
            n_beats_out++;
            if (estimate_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat actual=%h", $time, out_if.data);
            end else begin
                e = estimate_q.pop_front();
                if (e.step_status < 5) st_count[e.step_status]++;
                if (out_if.data.angle_estimate !== e.angle_estimate) begin
                    errors++;
                    $display("%0t: angle expected=%h actual=%h", $time,
                             e.angle_estimate, out_if.data.angle_estimate);
                end
                if (out_if.data.bias_estimate !== e.bias_estimate) begin
                    errors++;
                    $display("%0t: bias expected=%h actual=%h", $time,
                             e.bias_estimate, out_if.data.bias_estimate);
                end
                if (out_if.data.step_status !== e.step_status) begin
                    errors++;
                    $display("%0t: status expected=%0d actual=%0d", $time,
                             e.step_status, out_if.data.step_status);
                end
            end
        end
    end

    // receiver: random stall bursts, or a long counted hold-off
    initial begin
        int burst;
        out_if.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off > 0) begin
                out_if.ready <= 1'b0;
                repeat (hold_off) @(posedge i_clk);
                hold_off = 0;
            end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 3);
                out_if.ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_sample(t_in_beat b);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (estimate_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_noise(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_ANGLE_NOISE) noise_q = longint'(v);
        else if (idx == REG_BIAS_NOISE) noise_b = longint'(v);
        else if (idx == REG_MEAS_NOISE) noise_r = longint'(v);
    endtask

    function automatic t_word rand_word();
        case ($urandom_range(0, 5))
            0: return t_word'($urandom);
            1: return W_MAX;
            2: return W_MIN;
            default: return t_word'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
        endcase
    endfunction

    function automatic t_in_beat rand_sample();
        t_in_beat b;
        int k;
        k = $urandom_range(0, 99);
        b.op = (k < 4);
        b.angle_valid = 1'($urandom_range(0, 1));
        b.angle_obs = k < 85 ? t_word'($signed($urandom_range(0, 32'h0C00_0000))
                                        - 32'sh0600_0000) : rand_word();
        b.gyro_omega = k < 85 ? t_word'($signed($urandom_range(0, 32'h0400_0000))
                                         - 32'sh0200_0000) : rand_word();
        if (k < 80) b.time_step = t_word'($urandom_range(1, 32'h0008_0000));
        else if (k < 90) b.time_step = -t_word'($urandom_range(0, 32'h7FFF_FFFF));
        else b.time_step = rand_word();
        return b;
    endfunction

    // directed rows: op, meas, gyro, dt, valid, check?, angle, bias, status
    typedef struct {
        logic op;
        t_word meas, gyro, dt;
        logic valid;
        bit typed;
        t_word exp_angle, exp_bias;
        t_status exp_st;
    } t_row;

    t_row rows[] = '{
        '{0, 32'sd0, 32'sd0, 32'sd0, 1, 1, 32'sd0, 32'sd0, ST_BAD_STEP},
        '{0, 32'sd0, 32'sd0, W_MIN, 0, 1, 32'sd0, 32'sd0, ST_BAD_STEP},
        '{1, W_MAX, 32'sd0, 32'sd0, 0, 1, W_MAX, 32'sd0, ST_RESEEDED},
        '{1, W_MIN, W_MAX, W_MIN, 1, 1, W_MIN, 32'sd0, ST_RESEEDED},
        '{0, 32'sd0, W_MAX, W_MAX, 0, 0, 0, 0, ST_PREDICT},
        '{0, 32'sd0, W_MIN, W_MAX, 1, 0, 0, 0, ST_CORRECTED},
        '{1, 32'sd0, 32'sd0, 32'sd0, 0, 1, 32'sd0, 32'sd0, ST_RESEEDED},
        '{0, 32'sh0100_0000, 32'sh0010_0000, 32'sh0004_0000, 1, 0, 0, 0, ST_CORRECTED},
        '{0, 32'sh3000_0000, 32'sd0, 32'sh0004_0000, 1, 0, 0, 0, ST_CORRECTED},
        '{0, -32'sh3000_0000, 32'sd0, 32'sh0004_0000, 1, 0, 0, 0, ST_CORRECTED},
        '{0, W_MAX, W_MAX, 32'sh0100_0000, 1, 0, 0, 0, ST_CORRECTED},
        '{0, W_MIN, W_MIN, 32'sd1, 1, 0, 0, 0, ST_CORRECTED},
        '{0, 32'sd0, 32'sd0, W_MAX, 0, 0, 0, 0, ST_PREDICT},
        '{0, 32'sd0, 32'sd0, W_MAX, 1, 0, 0, 0, ST_CORRECTED},
        '{0, -32'sd1, -32'sd1, -32'sd1, 1, 0, 0, 0, ST_BAD_STEP},
        '{1, 32'sh0324_3F6A, 32'sd0, 32'sd1, 1, 1, 32'sh0324_3F6A, 32'sd0, ST_RESEEDED},
        '{0, -32'sh0324_3F6A, 32'sd0, 32'sd1, 1, 0, 0, 0, ST_CORRECTED}
    };

    initial begin
        t_in_beat b;
        t_row r;
        int n_sent;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        in_if.valid <= 1'b0;
        in_if.data <= '0;
        noise_q = longint'(DEF_ANGLE_NOISE);
        noise_b = longint'(DEF_BIAS_NOISE);
        noise_r = longint'(DEF_MEAS_NOISE);
        reseed_state(0);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            r = rows[i];
            b.op = r.op;
            b.angle_obs = r.meas;
            b.gyro_omega = r.gyro;
            b.time_step = r.dt;
            b.angle_valid = r.valid;
            send_sample(b);
            if (r.typed) begin
                // hold the input until this row's beat has come out
                in_if.valid <= 1'b0;
                wait (n_beats_out == i + 1);
                if (last_out.angle_estimate !== r.exp_angle
                    || last_out.bias_estimate !== r.exp_bias
                    || last_out.step_status !== r.exp_st) begin
                    errors++;
                    $display("%0t: row %0d expected=%h/%h/%0d actual=%h/%h/%0d", $time, i,
                             r.exp_angle, r.exp_bias, r.exp_st, last_out.angle_estimate,
                             last_out.bias_estimate, last_out.step_status);
                end
            end
        end
        drain();

        // noise settings: extremes, zero for defaults, then random mixes
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_noise(REG_ANGLE_NOISE, 31'd1);
                    write_noise(REG_BIAS_NOISE, 31'd1);
                    write_noise(REG_MEAS_NOISE, 31'd1);
                end
                1: begin
                    write_noise(REG_ANGLE_NOISE, 31'h7FFF_FFFF);
                    write_noise(REG_BIAS_NOISE, 31'h7FFF_FFFF);
                    write_noise(REG_MEAS_NOISE, 31'h7FFF_FFFF);
                end
                2: begin
                    write_noise(REG_ANGLE_NOISE, 31'd0);
                    write_noise(REG_BIAS_NOISE, 31'd0);
                    write_noise(REG_MEAS_NOISE, 31'd0);
                    write_noise(REG_UNUSED, 31'h1234);
                end
                default: begin
                    write_noise(REG_ANGLE_NOISE, CFG_BITS'($urandom_range(1, 31'h0010_0000)));
                    write_noise(REG_BIAS_NOISE, CFG_BITS'($urandom_range(1, 31'h0010_0000)));
                    write_noise(REG_MEAS_NOISE, ph == 5 ? 31'h7FFF_FFFF
                                : CFG_BITS'($urandom_range(1, 31'h0100_0000)));
                end
            endcase
            if (ph == 5) begin
                sink_idle_en = 0;
                src_idle_en = 0;
            end
            for (n_sent = 0; n_sent < N_RANDOM / 6; n_sent++) begin
                if (ph == 3 && n_sent == 20) hold_off = 3000;
                if (ph == 4 && n_sent == 30) drain();
                send_sample(rand_sample());
            end
            drain();
        end

        $display("Ran %0d beats: corrected %0d, predict %0d, bad step %0d,",
                 n_beats_out, st_count[0], st_count[1], st_count[2]);
        $display("reseed %0d, correction skipped %0d, over six noise settings.",
                 st_count[3], st_count[4]);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[angle_bias_kalman_filter.f]
src/abkf_pkg.sv
src/abkf_if.sv
src/abkf_mul.sv
src/abkf_div.sv
src/angle_bias_kalman_filter.sv
test/tb_angle_bias_kalman_filter.sv
